>>> rtl/core/fmc_pkg.sv
package fmc_pkg;

    localparam int NUM_CH    = 20;
    localparam int CH_W      = 5;
    localparam int SAMPLE_W  = 12;
    localparam int PTR_W     = 4;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CH_W-1:0] CH_SD_OUT = 5'd16;
    localparam logic [CH_W-1:0] CH_SD_IN  = 5'd17;
    localparam logic [CH_W-1:0] CH_SD_BMS = 5'd18;
    localparam logic [CH_W-1:0] CH_SD_IMD = 5'd19;
    localparam logic [CH_W-1:0] CH_LAST   = 5'd19;

    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MASK      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LEVELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HANDCART_MODE   = 2'd2;

    // 12-bit ADC codes, 13 bits wide so the check-mux upper bound fits
    localparam logic [12:0] MUX_LO    = 13'd868;
    localparam logic [12:0] MUX_HI    = 13'd2357;
    localparam logic [12:0] SD_LO     = 13'd289;
    localparam logic [12:0] SD_HI     = 13'd2891;
    localparam logic [12:0] CKM_LO    = 13'd2978;
    localparam logic [12:0] CKM_HI    = 13'd4219;
    localparam logic [12:0] IMD_HC_LO = 13'd868;
    localparam logic [12:0] IMD_HC_HI = 13'd1861;
    localparam logic [12:0] CKM_HC_LO = 13'd1613;
    localparam logic [12:0] CKM_HC_HI = 13'd2233;

    typedef enum logic [1:0] {
        ST_LOW  = 2'd0,
        ST_HIGH = 2'd1,
        ST_ERR  = 2'd2
    } level_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic handcart;
        logic imd_hc;
        logic ckm;
        logic mux;
    } chan_class_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mux_sample;
        logic [SAMPLE_W-1:0] sd_imd_sample;
        logic [SAMPLE_W-1:0] sd_bms_sample;
        logic [SAMPLE_W-1:0] sd_in_sample;
        logic [SAMPLE_W-1:0] sd_out_sample;
        logic [CH_W-1:0]     query_channel;
    } req_t;

    typedef struct packed {
        logic                check_ok;
        logic [CH_W-1:0]     fail_channel;
        logic [SAMPLE_W-1:0] query_sample;
        level_t              query_slot_state;
        level_t              query_majority_state;
    } rsp_t;

    function automatic level_t classify(chan_class_t c, logic [SAMPLE_W-1:0] v);
        logic [12:0] x;
        logic [12:0] lo;
        logic [12:0] hi;
        level_t      r;
        x  = {1'b0, v};
        lo = SD_LO;
        hi = SD_HI;
        if (c.imd_hc)
        begin
            lo = IMD_HC_LO;
            hi = IMD_HC_HI;
        end
        else if (c.mux && !c.ckm)
        begin
            lo = MUX_LO;
            hi = MUX_HI;
        end
        if (!c.imd_hc && c.ckm)
        begin
            lo = c.handcart ? CKM_HC_LO : CKM_LO;
            hi = c.handcart ? CKM_HC_HI : CKM_HI;
            r  = (x >= hi || x <= lo) ? ST_ERR : ST_HIGH;
        end
        else if (x <= lo)
        begin
            r = ST_LOW;
        end
        else if (x >= hi)
        begin
            r = ST_HIGH;
        end
        else
        begin
            r = ST_ERR;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/fmc_vote.sv
module fmc_vote #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic [HISTORY_DEPTH-1:0][fmc_pkg::SAMPLE_W-1:0] samples,
    input  fmc_pkg::chan_class_t                            cls,
    output fmc_pkg::level_t                                 levels [HISTORY_DEPTH],
    output fmc_pkg::level_t                                 majority
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    logic [CNT_W-1:0] cnt_lo;
    logic [CNT_W-1:0] cnt_hi;
    logic [CNT_W-1:0] cnt_err;

    always_comb
    begin
        cnt_lo  = '0;
        cnt_hi  = '0;
        cnt_err = '0;
        for (int j = 0; j < HISTORY_DEPTH; j++)
        begin
            levels[j] = fmc_pkg::classify(cls, samples[j]);
            case (levels[j])
                fmc_pkg::ST_LOW:  cnt_lo  = cnt_lo + CNT_W'(1);
                fmc_pkg::ST_HIGH: cnt_hi  = cnt_hi + CNT_W'(1);
                default:          cnt_err = cnt_err + CNT_W'(1);
            endcase
        end
    end

    always_comb
    begin
        if (cnt_lo > cnt_hi && cnt_lo > cnt_err)
        begin
            majority = fmc_pkg::ST_LOW;
        end
        else if (cnt_hi > cnt_lo && cnt_hi > cnt_err)
        begin
            majority = fmc_pkg::ST_HIGH;
        end
        else
        begin
            majority = fmc_pkg::ST_ERR;
        end
    end

endmodule

>>> rtl/core/feedback_majority_checker.sv
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_stall | fmc_pkg::req_t
// rsp     | out       | rsp_valid/rsp_stall | fmc_pkg::rsp_t
// cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// A word passes through accept, one read per channel over the 20-row history
// memory, one drain and one output load. The history memory has a single read
// port, so the scan reads the channels one after another.
// Reset empties the history through per-row valid bits; no clearing pass.
// req_stall is high from accept until the result is in the output register;
// a stalled rsp holds the block in its final state.
module feedback_majority_checker #(
    parameter int MUX_CHANNELS      = 16,
    parameter int HISTORY_DEPTH     = 5,
    parameter int CHECK_MUX_CHANNEL = 14,
    parameter int IMD_FAULT_CHANNEL = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  fmc_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output fmc_pkg::rsp_t                     rsp,
    input  logic                              cfg_we,
    input  logic [fmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fmc_pkg::CFG_W-1:0]         cfg_data
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW     = fmc_pkg::SAMPLE_W;
    localparam int CW     = fmc_pkg::CH_W;

    typedef logic [HISTORY_DEPTH-1:0][SW-1:0] row_t;

    fmc_pkg::fsm_t state_reg, state_next;

    logic [fmc_pkg::CFG_W-1:0] mask_reg;
    logic [fmc_pkg::CFG_W-1:0] expect_reg;
    logic                      hc_reg;

    fmc_pkg::req_t              item_reg;
    logic [CW-1:0]              scan_ch_reg;
    logic [CW-1:0]              proc_ch_reg;
    logic                       proc_vld_reg;
    logic [fmc_pkg::PTR_W-1:0]  mux_ptr_reg;

    logic                       ok_reg;
    logic [CW-1:0]              fail_reg;
    logic [SW-1:0]              q_samp_reg;
    fmc_pkg::level_t            q_slot_reg;
    fmc_pkg::level_t            q_maj_reg;

    fmc_pkg::rsp_t              rsp_reg;
    logic                       rsp_valid_reg;

    // history and write-slot memories, one row per channel
    row_t                       hist_mem [fmc_pkg::NUM_CH];
    logic [SLOT_W-1:0]          slot_mem [fmc_pkg::NUM_CH];
    logic [fmc_pkg::NUM_CH-1:0] row_vld_reg;
    row_t                       rd_row_reg;
    logic [SLOT_W-1:0]          rd_slot_reg;
    logic                       rd_vld_reg;

    logic                       accept;
    logic                       rsp_load;
    logic                       row_we;

    row_t                       cur_row;
    logic [SLOT_W-1:0]          cur_slot;
    row_t                       new_row;
    logic [SLOT_W-1:0]          new_slot;
    logic [SW-1:0]              wr_samp;
    fmc_pkg::chan_class_t       cls;
    fmc_pkg::level_t            levels [HISTORY_DEPTH];
    fmc_pkg::level_t            maj;
    logic                       ch_fail;

    assign accept = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fmc_pkg::FSM_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fmc_pkg::FSM_SCAN;
                end
            end
            fmc_pkg::FSM_SCAN:
            begin
                if (scan_ch_reg == fmc_pkg::CH_LAST)
                begin
                    state_next = fmc_pkg::FSM_DRAIN;
                end
            end
            fmc_pkg::FSM_DRAIN:
            begin
                state_next = fmc_pkg::FSM_DONE;
            end
            fmc_pkg::FSM_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = fmc_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = fmc_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rsp_load  = 1'b0;
        case (state_reg)
            fmc_pkg::FSM_IDLE:
            begin
                req_stall = 1'b0;
            end
            fmc_pkg::FSM_DONE:
            begin
                rsp_load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fmc_pkg::FSM_IDLE;
            scan_ch_reg  <= '0;
            proc_ch_reg  <= '0;
            proc_vld_reg <= 1'b0;
            mux_ptr_reg  <= '0;
            mask_reg     <= '0;
            expect_reg   <= '0;
            hc_reg       <= 1'b0;
            ok_reg       <= 1'b1;
            fail_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            proc_vld_reg <= (state_reg == fmc_pkg::FSM_SCAN);
            proc_ch_reg  <= scan_ch_reg;
            if (accept)
            begin
                scan_ch_reg <= '0;
            end
            else if (state_reg == fmc_pkg::FSM_SCAN && scan_ch_reg != fmc_pkg::CH_LAST)
            begin
                scan_ch_reg <= scan_ch_reg + CW'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fmc_pkg::REG_CHECK_MASK:      mask_reg   <= cfg_data;
                    fmc_pkg::REG_EXPECTED_LEVELS: expect_reg <= cfg_data;
                    fmc_pkg::REG_HANDCART_MODE:   hc_reg     <= cfg_data[0];
                    default:                      hc_reg     <= hc_reg;
                endcase
            end
            if (accept)
            begin
                ok_reg   <= 1'b1;
                fail_reg <= '0;
            end
            else if (proc_vld_reg && ok_reg && ch_fail)
            begin
                ok_reg   <= 1'b0;
                fail_reg <= proc_ch_reg;
            end
            if (rsp_load)
            begin
                mux_ptr_reg <= (mux_ptr_reg == fmc_pkg::PTR_W'(MUX_CHANNELS - 1))
                             ? '0 : mux_ptr_reg + fmc_pkg::PTR_W'(1);
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= req;
            q_samp_reg <= '0;
            q_slot_reg <= fmc_pkg::ST_ERR;
            q_maj_reg  <= fmc_pkg::ST_ERR;
        end
        else if (proc_vld_reg && proc_ch_reg == item_reg.query_channel)
        begin
            q_samp_reg <= new_row[new_slot];
            q_slot_reg <= levels[new_slot];
            q_maj_reg  <= maj;
        end
        if (rsp_load)
        begin
            rsp_reg.check_ok             <= ok_reg;
            rsp_reg.fail_channel         <= fail_reg;
            rsp_reg.query_sample         <= q_samp_reg;
            rsp_reg.query_slot_state     <= q_slot_reg;
            rsp_reg.query_majority_state <= q_maj_reg;
        end
    end

    // read row k while row k-1 is written back: rows never collide during the scan
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            hist_mem[proc_ch_reg] <= new_row;
            slot_mem[proc_ch_reg] <= new_slot;
        end
        rd_row_reg  <= hist_mem[scan_ch_reg];
        rd_slot_reg <= slot_mem[scan_ch_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (row_we)
            begin
                row_vld_reg[proc_ch_reg] <= 1'b1;
            end
            rd_vld_reg <= row_vld_reg[scan_ch_reg];
        end
    end

    always_comb
    begin
        cur_row  = rd_vld_reg ? rd_row_reg : '0;
        cur_slot = rd_vld_reg ? rd_slot_reg : '0;
        row_we   = proc_vld_reg
                && (proc_ch_reg >= fmc_pkg::CH_SD_OUT || proc_ch_reg == {1'b0, mux_ptr_reg});
        case (proc_ch_reg)
            fmc_pkg::CH_SD_OUT: wr_samp = item_reg.sd_out_sample;
            fmc_pkg::CH_SD_IN:  wr_samp = item_reg.sd_in_sample;
            fmc_pkg::CH_SD_BMS: wr_samp = item_reg.sd_bms_sample;
            fmc_pkg::CH_SD_IMD: wr_samp = item_reg.sd_imd_sample;
            default:            wr_samp = item_reg.mux_sample;
        endcase
        for (int j = 0; j < HISTORY_DEPTH; j++)
        begin
            new_row[j] = (row_we && cur_slot == SLOT_W'(j)) ? wr_samp : cur_row[j];
        end
        if (!row_we)
        begin
            new_slot = cur_slot;
        end
        else if (cur_slot == SLOT_W'(HISTORY_DEPTH - 1))
        begin
            new_slot = '0;
        end
        else
        begin
            new_slot = cur_slot + SLOT_W'(1);
        end
        cls.handcart = hc_reg;
        cls.imd_hc   = hc_reg && proc_ch_reg == CW'(IMD_FAULT_CHANNEL);
        cls.ckm      = proc_ch_reg == CW'(CHECK_MUX_CHANNEL);
        cls.mux      = proc_ch_reg < CW'(MUX_CHANNELS);
    end

    fmc_vote #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_vote (
        .samples  (new_row),
        .cls      (cls),
        .levels   (levels),
        .majority (maj)
    );

    always_comb
    begin
        ch_fail = 1'b0;
        if (mask_reg[proc_ch_reg])
        begin
            if (!cls.imd_hc && cls.ckm)
            begin
                ch_fail = (maj != fmc_pkg::ST_HIGH);
            end
            else
            begin
                ch_fail = (maj == fmc_pkg::ST_ERR)
                       || ( expect_reg[proc_ch_reg] && maj == fmc_pkg::ST_LOW)
                       || (!expect_reg[proc_ch_reg] && maj == fmc_pkg::ST_HIGH);
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_proc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        proc_vld_reg |-> proc_ch_reg <= fmc_pkg::CH_LAST)
        else $error("processed channel out of range");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == fmc_pkg::FSM_SCAN && scan_ch_reg == '0))
        else $error("scan did not start at channel 0");

    a_fail_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ok_reg) |-> $past(proc_vld_reg))
        else $error("check failed outside a channel update");

    a_write_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (state_reg == fmc_pkg::FSM_SCAN || state_reg == fmc_pkg::FSM_DRAIN))
        else $error("history write outside scan");

    a_load_clears_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> (rsp_valid_reg && (rsp_reg.check_ok || rsp_reg.fail_channel != '0
                      || $past(fail_reg) == '0)))
        else $error("result load inconsistent");

endmodule

>>> sim/feedback_majority_checker_tb.sv
module feedback_majority_checker_tb;

    localparam int DEPTH        = 5;
    localparam int MUX_CNT      = 16;
    localparam int CKM_CH       = 14;
    localparam int IMD_CH       = 13;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 85;

    localparam int TH_MUX_LO    = 868;
    localparam int TH_MUX_HI    = 2357;
    localparam int TH_SD_LO     = 289;
    localparam int TH_SD_HI     = 2891;
    localparam int TH_CKM_LO    = 2978;
    localparam int TH_CKM_HI    = 4219;
    localparam int TH_IMD_HC_LO = 868;
    localparam int TH_IMD_HC_HI = 1861;
    localparam int TH_CKM_HC_LO = 1613;
    localparam int TH_CKM_HC_HI = 2233;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    fmc_pkg::req_t                 req = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    fmc_pkg::rsp_t                 rsp;
    logic                          cfg_we = 1'b0;
    logic [fmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fmc_pkg::CFG_W-1:0]     cfg_data = '0;

    feedback_majority_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // channel history mirror
    bit [11:0]  hist_code [fmc_pkg::NUM_CH][DEPTH];
    int         hist_slot [fmc_pkg::NUM_CH];
    int         mux_ptr;
    logic [19:0] reg_mask;
    logic [19:0] reg_levels;
    bit         reg_hc;

    fmc_pkg::req_t queued_conversions [$];
    fmc_pkg::rsp_t pending_verdicts [$];
    int         err_count;
    int         cycle_count;
    logic       req_fire = 1'b0;
    int         burst_left = 1;
    int         gap_left;
    int         stall_left;

    function automatic void band(int ch, bit hc, output int lo, output int hi);
        if (hc && ch == IMD_CH)
        begin
            lo = TH_IMD_HC_LO;
            hi = TH_IMD_HC_HI;
        end
        else if (ch == CKM_CH)
        begin
            lo = hc ? TH_CKM_HC_LO : TH_CKM_LO;
            hi = hc ? TH_CKM_HC_HI : TH_CKM_HI;
        end
        else if (ch < MUX_CNT)
        begin
            lo = TH_MUX_LO;
            hi = TH_MUX_HI;
        end
        else
        begin
            lo = TH_SD_LO;
            hi = TH_SD_HI;
        end
    endfunction

    function automatic fmc_pkg::level_t code_level(int ch, int v);
        int lo;
        int hi;
        band(ch, reg_hc, lo, hi);
        if (ch == CKM_CH)
            return (v >= hi || v <= lo) ? fmc_pkg::ST_ERR : fmc_pkg::ST_HIGH;
        if (v <= lo)
            return fmc_pkg::ST_LOW;
        if (v >= hi)
            return fmc_pkg::ST_HIGH;
        return fmc_pkg::ST_ERR;
    endfunction

    function automatic fmc_pkg::level_t majority_of(int ch);
        int n_lo;
        int n_hi;
        int n_err;
        fmc_pkg::level_t st;
        n_lo = 0;
        n_hi = 0;
        n_err = 0;
        for (int k = 0; k < DEPTH; k++)
        begin
            st = code_level(ch, hist_code[ch][k]);
            if (st == fmc_pkg::ST_LOW)
                n_lo++;
            else if (st == fmc_pkg::ST_HIGH)
                n_hi++;
            else
                n_err++;
        end
        if (n_lo > n_hi && n_lo > n_err)
            return fmc_pkg::ST_LOW;
        if (n_hi > n_lo && n_hi > n_err)
            return fmc_pkg::ST_HIGH;
        return fmc_pkg::ST_ERR;
    endfunction

    function automatic void store_code(int ch, logic [11:0] v);
        hist_code[ch][hist_slot[ch]] = v;
        hist_slot[ch] = (hist_slot[ch] + 1) % DEPTH;
    endfunction

    function automatic fmc_pkg::rsp_t vote_and_check(fmc_pkg::req_t w);
        fmc_pkg::rsp_t   r;
        int              q;
        bit              done;
        fmc_pkg::level_t st;
        fmc_pkg::level_t want;
        store_code(mux_ptr, w.mux_sample);
        store_code(fmc_pkg::CH_SD_IN, w.sd_in_sample);
        store_code(fmc_pkg::CH_SD_OUT, w.sd_out_sample);
        store_code(fmc_pkg::CH_SD_BMS, w.sd_bms_sample);
        store_code(fmc_pkg::CH_SD_IMD, w.sd_imd_sample);
        mux_ptr = (mux_ptr + 1) % MUX_CNT;

        r = '0;
        r.check_ok = 1'b1;
        done = 1'b0;
        for (int ch = 0; ch < fmc_pkg::NUM_CH; ch++)
        begin
            if (!done && reg_mask[ch])
            begin
                st = majority_of(ch);
                // check-mux must read high regardless of its expected bit
                want = (ch == CKM_CH || reg_levels[ch]) ? fmc_pkg::ST_HIGH : fmc_pkg::ST_LOW;
                if (st != want)
                begin
                    r.check_ok = 1'b0;
                    r.fail_channel = 5'(ch);
                    done = 1'b1;
                end
            end
        end

        q = w.query_channel;
        if (q < fmc_pkg::NUM_CH)
        begin
            r.query_sample = hist_code[q][hist_slot[q]];
            r.query_slot_state = code_level(q, r.query_sample);
            r.query_majority_state = majority_of(q);
        end
        else
        begin
            r.query_sample = '0;
            r.query_slot_state = fmc_pkg::ST_ERR;
            r.query_majority_state = fmc_pkg::ST_ERR;
        end
        return r;
    endfunction

    function automatic logic [11:0] pick_code(int ch, bit want_hi, bit hc, int noise_pct);
        int lo;
        int hi;
        int r;
        int v;
        band(ch, hc, lo, hi);
        r = $urandom_range(0, 99);
        if (r < noise_pct / 2)
            v = $urandom_range(0, 4095);
        else if (r < noise_pct)
        begin
            case ($urandom_range(0, 3))
                0:       v = lo;
                1:       v = lo + 1;
                2:       v = hi - 1;
                default: v = hi;
            endcase
        end
        else if (ch == CKM_CH)
            v = $urandom_range(lo + 1, (hi - 1 > 4095) ? 4095 : hi - 1);
        else if (want_hi)
            v = $urandom_range(hi, 4095);
        else
            v = $urandom_range(0, lo);
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    task automatic note_mismatch(string fld, logic [31:0] want, logic [31:0] got);
        err_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
    endtask

    // register mirror, prediction and result check
    always @(posedge clk)
    begin
        fmc_pkg::rsp_t want;
        if (!rst_n)
            req_fire <= 1'b0;
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fmc_pkg::REG_CHECK_MASK:      reg_mask = cfg_data;
                    fmc_pkg::REG_EXPECTED_LEVELS: reg_levels = cfg_data;
                    fmc_pkg::REG_HANDCART_MODE:   reg_hc = cfg_data[0];
                    default:                      ;
                endcase
            end
            req_fire <= req_valid && !req_stall;
            if (req_valid && !req_stall)
                pending_verdicts.push_back(vote_and_check(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result word with none expected, actual %h", $time, rsp);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (rsp.check_ok !== want.check_ok)
                        note_mismatch("check_ok", want.check_ok, rsp.check_ok);
                    if (rsp.fail_channel !== want.fail_channel)
                        note_mismatch("fail_channel", want.fail_channel, rsp.fail_channel);
                    if (rsp.query_sample !== want.query_sample)
                        note_mismatch("query_sample", want.query_sample, rsp.query_sample);
                    if (rsp.query_slot_state !== want.query_slot_state)
                        note_mismatch("query_slot_state", want.query_slot_state,
                                      rsp.query_slot_state);
                    if (rsp.query_majority_state !== want.query_majority_state)
                        note_mismatch("query_majority_state", want.query_majority_state,
                                      rsp.query_majority_state);
                end
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge clk)
    begin
        if (!req_valid || req_fire)
        begin
            if (gap_left > 0)
            begin
                req_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (queued_conversions.size() > 0)
            begin
                req <= queued_conversions.pop_front();
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver: stall runs, release runs and quiet stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (rsp_stall)
        begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(0, 60);
        end
        else if ($urandom_range(0, 3) != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 30);
        end
        else
            stall_left <= $urandom_range(20, 120);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic load_config(logic [19:0] mask, logic [19:0] levels, bit hc);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= fmc_pkg::REG_CHECK_MASK;
        cfg_data <= mask;
        @(negedge clk);
        cfg_index <= fmc_pkg::REG_EXPECTED_LEVELS;
        cfg_data <= levels;
        @(negedge clk);
        cfg_index <= fmc_pkg::REG_HANDCART_MODE;
        cfg_data <= {19'd0, hc};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (queued_conversions.size() != 0 || req_valid || pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int            edges [20];
        int            gen_ptr;
        int            noise;
        int            ch;
        logic [19:0]   mask;
        logic [19:0]   levels;
        logic [19:0]   intent;
        bit            hc;
        fmc_pkg::req_t w;

        edges = '{0, 4095, 868, 869, 2356, 2357, 289, 290, 2890, 2891,
                  2978, 2979, 1613, 1614, 2232, 2233, 1860, 1861, 2048, 1};
        gen_ptr = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // threshold edges on every field, queries in and beyond the channel range
        load_config(20'hFFFFF, 20'h0A5F3, 1'b0);
        for (int k = 0; k < 24; k++)
        begin
            w.mux_sample    = 12'(edges[k % 20]);
            w.sd_imd_sample = 12'(edges[(k + 5) % 20]);
            w.sd_bms_sample = 12'(edges[(k + 10) % 20]);
            w.sd_in_sample  = 12'(edges[(k + 15) % 20]);
            w.sd_out_sample = 12'(edges[(k + 7) % 20]);
            w.query_channel = (k < 20) ? 5'(k) : 5'(k + 8);
            queued_conversions.push_back(w);
            gen_ptr = (gen_ptr + 1) % MUX_CNT;
        end
        wait_idle();
        repeat (4) @(negedge clk);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       begin mask = 20'hFFFFF; levels = 20'($urandom); hc = 1'b0; end
                1:       begin mask = 20'hFFFFF; levels = 20'($urandom); hc = 1'b1; end
                2:       begin mask = 20'h00000; levels = 20'hFFFFF; hc = 1'b0; end
                3:       begin mask = 20'hFFFFF; levels = 20'h00000; hc = 1'b1; end
                4:       begin mask = 20'hFFFFF; levels = 20'hFFFFF; hc = 1'b0; end
                5:
                begin
                    mask = 20'($urandom);
                    levels = 20'($urandom);
                    hc = 1'($urandom);
                end
                6:       begin mask = 20'($urandom); levels = 20'($urandom); hc = 1'b1; end
                default: begin mask = 20'hFFFFF; levels = 20'($urandom); hc = 1'b0; end
            endcase
            load_config(mask, levels, hc);
            intent = levels;
            noise = $urandom_range(2, 25);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // drift one channel now and then so majorities change over
                if ($urandom_range(0, 39) == 0)
                begin
                    ch = $urandom_range(0, fmc_pkg::NUM_CH - 1);
                    intent[ch] = ~intent[ch];
                end
                w.mux_sample    = pick_code(gen_ptr, intent[gen_ptr], hc, noise);
                w.sd_imd_sample = pick_code(fmc_pkg::CH_SD_IMD, intent[fmc_pkg::CH_SD_IMD],
                                            hc, noise);
                w.sd_bms_sample = pick_code(fmc_pkg::CH_SD_BMS, intent[fmc_pkg::CH_SD_BMS],
                                            hc, noise);
                w.sd_in_sample  = pick_code(fmc_pkg::CH_SD_IN, intent[fmc_pkg::CH_SD_IN],
                                            hc, noise);
                w.sd_out_sample = pick_code(fmc_pkg::CH_SD_OUT, intent[fmc_pkg::CH_SD_OUT],
                                            hc, noise);
                w.query_channel = 5'($urandom_range(0, 31));
                queued_conversions.push_back(w);
                gen_ptr = (gen_ptr + 1) % MUX_CNT;
            end
            wait_idle();
            repeat (4) @(negedge clk);
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> feedback_majority_checker.f
rtl/core/fmc_pkg.sv
rtl/core/fmc_vote.sv
rtl/core/feedback_majority_checker.sv
sim/feedback_majority_checker_tb.sv
